// ===== src/video_frame_standard_detector_defines.svh =====
// assertion macros for the video frame standard detector
`ifndef VIDEO_FRAME_STANDARD_DETECTOR_DEFINES_SVH
`define VIDEO_FRAME_STANDARD_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked while out of reset
`define VFSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfsd check failed");

// next-cycle implication, checked while out of reset
`define VFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfsd check failed");

`else

`define VFSD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/vfsd_pkg.sv =====
// types and constants of the video frame standard detector
`default_nettype none

package vfsd_pkg;

    localparam int LINE_W     = 10;
    localparam int GARB_W     = 8;
    localparam int TOL_W      = 8;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    // lines of slack before the ideal count at which the wait counter starts
    localparam logic [LINE_W:0] LINE_MARGIN = 11'd3;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    localparam logic [LINE_W-1:0] NTSC_LINES_RST = 10'd262;
    localparam logic [LINE_W-1:0] PAL_LINES_RST  = 10'd312;
    localparam logic [LINE_W-1:0] WAIT_LIMIT_RST = 10'd100;
    localparam logic [GARB_W-1:0] GARBAGE_RST    = 8'd10;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NTSC_LINES = 3'd0,
        REG_PAL_LINES  = 3'd1,
        REG_WAIT_LIMIT = 3'd2,
        REG_GARBAGE    = 3'd3,
        REG_TOLERANCE  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_LINE  = 1'b0,
        ACT_VSYNC = 1'b1
    } action_t;

    typedef enum logic {
        ST_WAIT_START = 1'b0,
        ST_WAIT_END   = 1'b1
    } vsync_state_t;

    typedef enum logic {
        LAYOUT_NTSC = 1'b0,
        LAYOUT_PAL  = 1'b1
    } layout_t;

    function automatic logic [LINE_W-1:0] line_sat_inc(input logic [LINE_W-1:0] v);
        return (v == LINE_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_W-1:0] line_dist(input logic [LINE_W-1:0] a,
                                                   input logic [LINE_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

`default_nettype wire

// ===== src/video_frame_standard_detector.sv =====
// top level of the video frame standard detector
//
//  port group   dir  contents
//  s_axis_*     in   one event request: tuser = action, tdata = vsync level
//  m_axis_*     out  one result per event: tlast = frame done, tdata = counts
//  cfg_*        in   register writes, index 0..4, no read-back
//
// each event is handled at its accepting edge: state updates there and the
// result lands in the output register, so a new request is taken every cycle
// the output register is empty or being drained; a stalled output holds the
// input off. reset clears the vsync tracker, counters and tallies and loads the
// register defaults; there is no clearing pass.
`default_nettype none

`include "video_frame_standard_detector_defines.svh"

module video_frame_standard_detector (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // [0] vsync_level, [7:1] zero
    input  wire logic [vfsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  wire logic                                s_axis_tuser,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [9:0] frame_lines, [10] frame_layout, [26:11] ntsc_count,
    // [42:27] pal_count, [43] majority_layout, [47:44] zero
    output      logic [vfsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // frame_done
    output      logic                                m_axis_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vfsd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [vfsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LW = vfsd_pkg::LINE_W;
    localparam int CW = vfsd_pkg::CNT_W;

    // configuration
    logic [LW-1:0]                 ntsc_lines_reg;
    logic [LW-1:0]                 pal_lines_reg;
    logic [LW-1:0]                 wait_limit_reg;
    logic [vfsd_pkg::GARB_W-1:0]   garbage_reg;
    logic [vfsd_pkg::TOL_W-1:0]    tolerance_reg;

    // tracker state
    vfsd_pkg::vsync_state_t state_reg, state_next;
    vfsd_pkg::layout_t      layout_reg, layout_next;
    logic [LW-1:0]          wait_lines_reg, wait_lines_next;
    logic [LW-1:0]          line_count_reg, line_count_next;
    logic [LW-1:0]          last_lines_reg, last_lines_next;
    logic [CW-1:0]          frame_total_reg, frame_total_next;
    logic [CW-1:0]          ntsc_tally_reg, ntsc_tally_next;
    logic [CW-1:0]          pal_tally_reg, pal_tally_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_done_reg, done_next;
    logic [LW-1:0]          out_lines_reg;
    logic                   out_layout_reg;
    logic [CW-1:0]          out_ntsc_reg;
    logic [CW-1:0]          out_pal_reg;
    logic                   out_major_reg;

    logic                   accept;
    vfsd_pkg::action_t      action;
    logic                   vsync_level;

    // combinational helpers
    vfsd_pkg::vsync_state_t target;
    vfsd_pkg::layout_t      chosen;
    logic [LW-1:0]          lc_inc;
    logic [LW-1:0]          wl_inc;
    logic [LW-1:0]          wl_new;
    logic [LW-1:0]          ideal;
    logic [LW-1:0]          class_lines;
    logic [LW-1:0]          dn;
    logic [LW-1:0]          dp;
    logic [LW-1:0]          dmin;
    logic                   pick_pal;
    logic                   do_class;

    assign action        = vfsd_pkg::action_t'(s_axis_tuser);
    assign vsync_level   = s_axis_tdata[0];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tdata  = {4'b0, out_major_reg, out_pal_reg, out_ntsc_reg,
                            out_layout_reg, out_lines_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntsc_lines_reg <= vfsd_pkg::NTSC_LINES_RST;
            pal_lines_reg  <= vfsd_pkg::PAL_LINES_RST;
            wait_limit_reg <= vfsd_pkg::WAIT_LIMIT_RST;
            garbage_reg    <= vfsd_pkg::GARBAGE_RST;
            tolerance_reg  <= vfsd_pkg::TOLERANCE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (vfsd_pkg::cfg_reg_t'(cfg_addr))
                vfsd_pkg::REG_NTSC_LINES: ntsc_lines_reg <= cfg_wdata;
                vfsd_pkg::REG_PAL_LINES:  pal_lines_reg  <= cfg_wdata;
                vfsd_pkg::REG_WAIT_LIMIT: wait_limit_reg <= cfg_wdata;
                vfsd_pkg::REG_GARBAGE:    garbage_reg    <= cfg_wdata[vfsd_pkg::GARB_W-1:0];
                vfsd_pkg::REG_TOLERANCE:  tolerance_reg  <= cfg_wdata[vfsd_pkg::TOL_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        layout_next      = layout_reg;
        wait_lines_next  = wait_lines_reg;
        line_count_next  = line_count_reg;
        last_lines_next  = last_lines_reg;
        frame_total_next = frame_total_reg;
        ntsc_tally_next  = ntsc_tally_reg;
        pal_tally_next   = pal_tally_reg;
        done_next        = 1'b0;
        do_class         = 1'b0;
        class_lines      = line_count_reg;
        wl_new           = wait_lines_reg;

        target = vsync_level ? vfsd_pkg::ST_WAIT_END : vfsd_pkg::ST_WAIT_START;
        lc_inc = vfsd_pkg::line_sat_inc(line_count_reg);
        wl_inc = vfsd_pkg::line_sat_inc(wait_lines_reg);
        ideal  = (layout_reg == vfsd_pkg::LAYOUT_PAL) ? pal_lines_reg : ntsc_lines_reg;

        if (accept)
        begin
            if (action == vfsd_pkg::ACT_VSYNC)
            begin
                if (target != state_reg)
                begin
                    state_next      = target;
                    wait_lines_next = '0;
                    if (target == vfsd_pkg::ST_WAIT_START)
                    begin
                        do_class        = 1'b1;
                        class_lines     = line_count_reg;
                        line_count_next = '0;
                    end
                end
            end
            else
            begin
                line_count_next = lc_inc;
                if (state_reg == vfsd_pkg::ST_WAIT_START)
                begin
                    // wait counter runs only near the expected frame end, or before any frame has completed
                    if (({1'b0, lc_inc} + vfsd_pkg::LINE_MARGIN > {1'b0, ideal})
                        || (frame_total_reg == '0))
                    begin
                        wl_new = wl_inc;
                    end
                    if (wl_new > wait_limit_reg)
                    begin
                        state_next      = vfsd_pkg::ST_WAIT_END;
                        wait_lines_next = '0;
                    end
                    else
                    begin
                        wait_lines_next = wl_new;
                    end
                end
                else
                begin
                    wl_new = wl_inc;
                    if (wl_new > wait_limit_reg)
                    begin
                        // vsync end never came, force the frame end
                        state_next      = vfsd_pkg::ST_WAIT_START;
                        wait_lines_next = '0;
                        do_class        = 1'b1;
                        class_lines     = lc_inc;
                        line_count_next = '0;
                    end
                    else
                    begin
                        wait_lines_next = wl_new;
                    end
                end
            end
        end

        dn       = vfsd_pkg::line_dist(class_lines, ntsc_lines_reg);
        dp       = vfsd_pkg::line_dist(class_lines, pal_lines_reg);
        dmin     = (dn < dp) ? dn : dp;
        pick_pal = dn > dp;

        if (dmin <= {2'b0, tolerance_reg})
        begin
            chosen = vfsd_pkg::layout_t'(pick_pal);
        end
        else if ((class_lines < pal_lines_reg) && (class_lines > ntsc_lines_reg)
                 && class_lines[0])
        begin
            chosen = vfsd_pkg::LAYOUT_NTSC;
        end
        else
        begin
            chosen = vfsd_pkg::layout_t'(pick_pal);
        end

        if (do_class)
        begin
            last_lines_next  = class_lines;
            frame_total_next = vfsd_pkg::cnt_sat_inc(frame_total_reg);
            done_next        = 1'b1;
            if (frame_total_next > {8'b0, garbage_reg})
            begin
                layout_next = chosen;
                if (chosen == vfsd_pkg::LAYOUT_NTSC)
                begin
                    ntsc_tally_next = vfsd_pkg::cnt_sat_inc(ntsc_tally_reg);
                end
                else
                begin
                    pal_tally_next = vfsd_pkg::cnt_sat_inc(pal_tally_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vfsd_pkg::ST_WAIT_START;
            layout_reg      <= vfsd_pkg::LAYOUT_NTSC;
            wait_lines_reg  <= '0;
            line_count_reg  <= '0;
            last_lines_reg  <= '0;
            frame_total_reg <= '0;
            ntsc_tally_reg  <= '0;
            pal_tally_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            layout_reg      <= layout_next;
            wait_lines_reg  <= wait_lines_next;
            line_count_reg  <= line_count_next;
            last_lines_reg  <= last_lines_next;
            frame_total_reg <= frame_total_next;
            ntsc_tally_reg  <= ntsc_tally_next;
            pal_tally_reg   <= pal_tally_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_done_reg   <= done_next;
            out_lines_reg  <= last_lines_next;
            out_layout_reg <= layout_next;
            out_ntsc_reg   <= ntsc_tally_next;
            out_pal_reg    <= pal_tally_next;
            out_major_reg  <= pal_tally_next > ntsc_tally_next;
        end
    end

    // a waiting result holds the input side off
    `VFSD_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready)

    // tallies only move after at least one frame has completed
    `VFSD_ASSERT_NOW(a_tally_needs_frame, clk, rst_n,
        (ntsc_tally_reg != '0) || (pal_tally_reg != '0), frame_total_reg != '0)

    // vsync falling while waiting for its end always completes a frame
    `VFSD_ASSERT_NEXT(a_vsync_end_done, clk, rst_n,
        accept && (action == vfsd_pkg::ACT_VSYNC) && !vsync_level
        && (state_reg == vfsd_pkg::ST_WAIT_END), m_axis_tvalid && m_axis_tlast)

endmodule

`default_nettype wire

// ===== test/tb_video_frame_standard_detector.sv =====
// testbench for the video frame standard detector: event stream checked against a local predictor
`timescale 1ns / 100ps

module tb_video_frame_standard_detector;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 21;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 4;
    localparam int HOLD_CYCLES  = 60;
    // lines of slack before the ideal count at which the wait counter runs
    localparam int LINE_SLACK   = 3;
    localparam int LW           = vfsd_pkg::LINE_W;
    localparam int CW           = vfsd_pkg::CNT_W;
    localparam int GW           = vfsd_pkg::GARB_W;
    localparam int TW           = vfsd_pkg::TOL_W;
    localparam int DW           = vfsd_pkg::CFG_DATA_W;

    typedef struct {
        logic              frame_done;
        logic [LW-1:0]     frame_lines;
        vfsd_pkg::layout_t frame_layout;
        logic [CW-1:0]     ntsc_count;
        logic [CW-1:0]     pal_count;
        logic              majority;
    } detector_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // [0] vsync_level, [7:1] zero
    logic [vfsd_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    // [0] action
    logic                              s_axis_tuser  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [9:0] frame_lines, [10] frame_layout, [26:11] ntsc_count,
    // [42:27] pal_count, [43] majority_layout, [47:44] zero
    logic [vfsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    // frame_done
    logic                              m_axis_tlast;
    logic                              cfg_wr_en     = 1'b0;
    logic [vfsd_pkg::CFG_IDX_W-1:0]    cfg_addr      = '0;
    logic [DW-1:0]                     cfg_wdata     = '0;

    // predicted detector state
    logic [LW-1:0]          cfg_ntsc   = vfsd_pkg::NTSC_LINES_RST;
    logic [LW-1:0]          cfg_pal    = vfsd_pkg::PAL_LINES_RST;
    logic [LW-1:0]          cfg_wait   = vfsd_pkg::WAIT_LIMIT_RST;
    logic [GW-1:0]          cfg_garb   = vfsd_pkg::GARBAGE_RST;
    logic [TW-1:0]          cfg_tol    = vfsd_pkg::TOLERANCE_RST;
    vfsd_pkg::vsync_state_t vs_state   = vfsd_pkg::ST_WAIT_START;
    logic [LW-1:0]          wait_cnt   = '0;
    logic [LW-1:0]          lines_now  = '0;
    logic [LW-1:0]          lines_last = '0;
    logic [CW-1:0]          frames     = '0;
    vfsd_pkg::layout_t      layout     = vfsd_pkg::LAYOUT_NTSC;
    logic [CW-1:0]          tally_ntsc = '0;
    logic [CW-1:0]          tally_pal  = '0;
    logic                   frame_closed;

    detector_report_t reports_due[$];

    int  mismatch_count = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;
    int  hold_request   = 0;
    int  hold_left      = 0;
    int  quiet_cycles   = 0;

    video_frame_standard_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // latch the frame, then classify once past the garbage frames
    function automatic void close_frame();
        logic [LW-1:0] dn;
        logic [LW-1:0] dp;
        lines_last = lines_now;
        if (frames != vfsd_pkg::CNT_MAX)
            frames++;
        frame_closed = 1'b1;
        if (frames <= CW'(cfg_garb))
            return;
        dn = (lines_last > cfg_ntsc) ? lines_last - cfg_ntsc : cfg_ntsc - lines_last;
        dp = (lines_last > cfg_pal) ? lines_last - cfg_pal : cfg_pal - lines_last;
        if (((dn < dp) ? dn : dp) <= LW'(cfg_tol))
            layout = (dn <= dp) ? vfsd_pkg::LAYOUT_NTSC : vfsd_pkg::LAYOUT_PAL;
        else if (lines_last < cfg_pal && lines_last > cfg_ntsc && lines_last[0])
            layout = vfsd_pkg::LAYOUT_NTSC;
        else
            layout = (dn <= dp) ? vfsd_pkg::LAYOUT_NTSC : vfsd_pkg::LAYOUT_PAL;
        if (layout == vfsd_pkg::LAYOUT_NTSC)
        begin
            if (tally_ntsc != vfsd_pkg::CNT_MAX)
                tally_ntsc++;
        end
        else
        begin
            if (tally_pal != vfsd_pkg::CNT_MAX)
                tally_pal++;
        end
    endfunction

    function automatic void switch_state(input vfsd_pkg::vsync_state_t s);
        if (s == vs_state)
            return;
        vs_state = s;
        wait_cnt = '0;
        if (s == vfsd_pkg::ST_WAIT_START)
        begin
            close_frame();
            lines_now = '0;
        end
    endfunction

    function automatic void advance_detector(input vfsd_pkg::action_t act, input logic lvl);
        logic [LW-1:0]    ideal;
        detector_report_t r;
        frame_closed = 1'b0;
        if (act == vfsd_pkg::ACT_VSYNC)
        begin
            switch_state(lvl ? vfsd_pkg::ST_WAIT_END : vfsd_pkg::ST_WAIT_START);
        end
        else
        begin
            if (lines_now != vfsd_pkg::LINE_MAX)
                lines_now++;
            ideal = (layout == vfsd_pkg::LAYOUT_NTSC) ? cfg_ntsc : cfg_pal;
            if (vs_state == vfsd_pkg::ST_WAIT_START)
            begin
                if (int'(lines_now) + LINE_SLACK > int'(ideal) || frames == '0)
                begin
                    if (wait_cnt != vfsd_pkg::LINE_MAX)
                        wait_cnt++;
                end
                if (wait_cnt > cfg_wait)
                    switch_state(vfsd_pkg::ST_WAIT_END);
            end
            else
            begin
                if (wait_cnt != vfsd_pkg::LINE_MAX)
                    wait_cnt++;
                if (wait_cnt > cfg_wait)
                    switch_state(vfsd_pkg::ST_WAIT_START);
            end
        end
        r.frame_done   = frame_closed;
        r.frame_lines  = lines_last;
        r.frame_layout = layout;
        r.ntsc_count   = tally_ntsc;
        r.pal_count    = tally_pal;
        r.majority     = (tally_pal > tally_ntsc);
        reports_due.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [CW-1:0] got,
                               input logic [CW-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // result side: check each accepted result, then decide next cycle's ready
    always @(posedge clk)
    begin : report_check
        detector_report_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (reports_due.size() == 0)
            begin
                report_mismatch("result with no request pending", '0, '0);
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("frame_done", CW'(m_axis_tlast), CW'(want.frame_done));
                check_field("frame_lines", CW'(m_axis_tdata[9:0]), CW'(want.frame_lines));
                check_field("frame_layout", CW'(m_axis_tdata[10]), CW'(want.frame_layout));
                check_field("ntsc_count", m_axis_tdata[26:11], want.ntsc_count);
                check_field("pal_count", m_axis_tdata[42:27], want.pal_count);
                check_field("majority_layout", CW'(m_axis_tdata[43]), CW'(want.majority));
            end
        end
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready <= !(receiver_idles && ($urandom_range(99) < IDLE_PCT));
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_event(input vfsd_pkg::action_t act, input logic lvl);
        while (sender_idles && ($urandom_range(99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(vfsd_pkg::IN_DATA_W - 1){1'b0}}, lvl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_detector(act, lvl);
    endtask

    task automatic send_lines(input int n);
        repeat (n) send_event(vfsd_pkg::ACT_LINE, 1'($urandom_range(1)));
    endtask

    task automatic send_frame(input int n);
        send_lines(n);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b0);
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input vfsd_pkg::cfg_reg_t idx, input logic [DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic apply_settings(input logic [LW-1:0] ntsc, input logic [LW-1:0] pal,
                                  input logic [LW-1:0] wlim, input logic [GW-1:0] garb,
                                  input logic [TW-1:0] tol);
        write_reg(vfsd_pkg::REG_NTSC_LINES, ntsc);
        write_reg(vfsd_pkg::REG_PAL_LINES, pal);
        write_reg(vfsd_pkg::REG_WAIT_LIMIT, wlim);
        write_reg(vfsd_pkg::REG_GARBAGE, DW'(garb));
        write_reg(vfsd_pkg::REG_TOLERANCE, DW'(tol));
        cfg_wr_en <= 1'b0;
        cfg_ntsc = ntsc;
        cfg_pal  = pal;
        cfg_wait = wlim;
        cfg_garb = garb;
        cfg_tol  = tol;
    endtask

    task automatic test_directed();
        // repeated levels, and a frame end still inside the garbage frames
        send_event(vfsd_pkg::ACT_LINE, 1'b1);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b0);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b0);
        drain_reports();
        // tie goes to ntsc, odd count between the standards, exact pal match
        apply_settings(10'd2, 10'd6, vfsd_pkg::LINE_MAX, 8'd0, 8'd0);
        send_frame(4);
        send_frame(5);
        send_frame(6);
        drain_reports();
    endtask

    task automatic test_random_frames();
        int budget;
        int sent;
        int target;
        int tail;
        int spread;
        int k;
        logic [LW-1:0] std_lines;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_settings(vfsd_pkg::NTSC_LINES_RST, vfsd_pkg::PAL_LINES_RST,
                                  vfsd_pkg::WAIT_LIMIT_RST, vfsd_pkg::GARBAGE_RST,
                                  vfsd_pkg::TOLERANCE_RST);
                1: apply_settings(10'd12, 10'd16, 10'd6, 8'd0, 8'd2);
                2: apply_settings(10'd0, vfsd_pkg::LINE_MAX, 10'd0, 8'd0, 8'd0);
                3: apply_settings(vfsd_pkg::LINE_MAX, 10'd0, vfsd_pkg::LINE_MAX,
                                  8'd255, 8'd255);
                4: apply_settings(10'd1, 10'd2, 10'd3, 8'd0, 8'd1);
                5: apply_settings(10'd20, 10'd10, 10'd8, 8'd3, 8'd0);
                default: apply_settings(LW'($urandom_range(40)), LW'($urandom_range(40)),
                                        LW'($urandom_range(20)), GW'($urandom_range(5)),
                                        TW'($urandom_range(8)));
            endcase
            // one phase runs with both sides always ready
            sender_idles   = (phase != 3);
            receiver_idles = (phase != 3);
            budget = (phase == 0) ? 150 : 24;
            sent   = 0;
            while (sent < budget)
            begin
                if ($urandom_range(99) < 80)
                begin
                    std_lines = $urandom_range(1) ? cfg_pal : cfg_ntsc;
                    spread = int'(cfg_tol) + 4;
                    if (spread > 24)
                        spread = 24;
                    target = int'(std_lines) + int'($urandom_range(2 * spread)) - spread;
                    if (target < 0)
                        target = 0;
                    if (phase != 0 && target > 60)
                        target = int'($urandom_range(60));
                    tail = int'($urandom_range(3));
                    if (tail > target)
                        tail = target;
                    send_lines(target - tail);
                    send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
                    if ($urandom_range(9) == 0)
                    begin
                        send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
                        sent++;
                    end
                    send_lines(tail);
                    send_event(vfsd_pkg::ACT_VSYNC, 1'b0);
                    sent += target + 2;
                end
                else
                begin
                    k = int'($urandom_range(1, 4));
                    repeat (k) send_event(vfsd_pkg::action_t'($urandom_range(1)),
                                          1'($urandom_range(1)));
                    sent += k;
                end
            end
            drain_reports();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_backpressure();
        sender_idles = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_event(vfsd_pkg::action_t'($urandom_range(1)), 1'($urandom_range(1)));
        drain_reports();
        sender_idles = 1'b1;
    endtask

    task automatic test_line_saturation();
        // long stretch with both sides always ready
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        // limit at max: the wait counter pins at the top and never forces a change
        apply_settings(vfsd_pkg::NTSC_LINES_RST, vfsd_pkg::PAL_LINES_RST,
                       vfsd_pkg::LINE_MAX, 8'd0, vfsd_pkg::TOLERANCE_RST);
        send_lines(int'(vfsd_pkg::LINE_MAX) + 8);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b1);
        send_event(vfsd_pkg::ACT_VSYNC, 1'b0);
        drain_reports();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames();
        test_backpressure();
        test_line_saturation();
        drain_reports();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
